// File: sv/assert_macros.svh
// Assertion helper macros used by the engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ascon_pkg.sv
// ---------------------------------------------------------------------------
// ascon_pkg
// Types, constants and helpers for the Ascon-AEAD128 engine.
// ---------------------------------------------------------------------------
package ascon_pkg;

	localparam logic [63:0] IV_AEAD128 = 64'h0000_1000_808C_0001;
	localparam logic [63:0] DOMAIN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [3:0]  ROUNDS_INIT = 4'd12;
	localparam logic [3:0]  ROUNDS_DATA = 4'd8;

	// operation codes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_AD     = 2'd1;
	localparam logic [1:0] OP_MSG    = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_DECRYPT  = 2'd2;

	// message phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_AD     = 2'd1;
	localparam logic [1:0] PH_MSG    = 2'd2;
	localparam logic [1:0] PH_CLOSED = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] data_word0;
		logic [63:0] data_word1;
		logic [4:0]  byte_count;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_word0;
		logic [63:0] out_word1;
		logic [4:0]  out_bytes;
		logic        is_tag;
		logic        tag_match;
		logic        order_error;
	} out_item_t;

	typedef logic [63:0] state_t [5];

	// round constant for position idx of the 16-entry schedule;
	// position 4 is the first round of the 12-round schedule (0xf0)
	function automatic logic [7:0] round_const(input logic [3:0] idx);
		logic [7:0] rc;
		rc = {4'd3 - idx, idx + 4'd12};
		return rc;
	endfunction

	// low b bytes mask, b in 0..8
	function automatic logic [63:0] byte_mask(input logic [3:0] b);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < int'(b)) m[8*i +: 8] = 8'hFF;
		end
		return m;
	endfunction

	// 0x01 pad byte at position b, b in 0..7
	function automatic logic [63:0] pad_word(input logic [2:0] b);
		logic [63:0] p;
		p = '0;
		p[{b, 3'b000}] = 1'b1;
		return p;
	endfunction

endpackage

// File: sv/ascon_round.sv
// ---------------------------------------------------------------------------
// ascon_round
// Round sequencer: applies one Ascon permutation round per cycle to the
// state held in the top level, counting the schedule down.
// ---------------------------------------------------------------------------
module ascon_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  rounds,
	input  logic [63:0] x_in [5],
	output logic [63:0] x_out [5],
	output logic        busy
);
	import ascon_pkg::*;

	logic [3:0] idx_q;
	logic [3:0] left_q;
	logic [63:0] a [5];
	logic [63:0] t [5];
	logic [63:0] b [5];

	// round counter; idx_q walks the constant schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			left_q <= '0;
		end else if (start) begin
			idx_q  <= 4'(5'd16 - {1'b0, rounds});
			left_q <= rounds;
		end else if (left_q != 4'd0) begin
			idx_q  <= idx_q + 4'd1;
			left_q <= left_q - 4'd1;
		end
	end

	assign busy = (left_q != 4'd0);

	// one round of substitution and linear layer
	always_comb begin
		a[0] = x_in[0] ^ x_in[4];
		a[1] = x_in[1];
		a[2] = x_in[2] ^ {56'd0, round_const(idx_q)} ^ x_in[1];
		a[3] = x_in[3];
		a[4] = x_in[4] ^ x_in[3];
		for (int i = 0; i < 5; i++) t[i] = ~a[i] & a[(i+1)%5];
		for (int i = 0; i < 5; i++) b[i] = a[i] ^ t[(i+1)%5];
		b[1] = b[1] ^ b[0];
		b[0] = b[0] ^ b[4];
		b[3] = b[3] ^ b[2];
		b[2] = ~b[2];
		x_out[0] = b[0] ^ {b[0][18:0], b[0][63:19]} ^ {b[0][27:0], b[0][63:28]};
		x_out[1] = b[1] ^ {b[1][60:0], b[1][63:61]} ^ {b[1][38:0], b[1][63:39]};
		x_out[2] = b[2] ^ {b[2][0], b[2][63:1]} ^ {b[2][5:0], b[2][63:6]};
		x_out[3] = b[3] ^ {b[3][9:0], b[3][63:10]} ^ {b[3][16:0], b[3][63:17]};
		x_out[4] = b[4] ^ {b[4][6:0], b[4][63:7]} ^ {b[4][40:0], b[4][63:41]};
	end

endmodule

// File: sv/ascon_aead128_engine_top.sv
// ---------------------------------------------------------------------------
// ascon_aead128_engine_top
// Ascon-AEAD128 engine: start, AD, message and finish transactions.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one transaction: an operation
// with a 16-byte data block and a byte count. Output channel
// out_valid/out_stall carries message output, the tag or an order error.
// Configuration writes (key halves, decrypt mode) go through cfg_we,
// cfg_index and cfg_data; the user makes them only while the engine is
// idle, as the block itself does not enforce this. The permutation runs
// one round per cycle in a shared round unit, and the round count sets the
// rate. Rounds per accepted transaction: start 12, AD block 8, full message
// block 8, short message block and order error none, finish 12. A message
// block or finish that closes AD first absorbs an empty padded AD block
// with 8 rounds if the last AD block was full, then sets the domain bit.
// A new transaction can be accepted in the cycle after a result is taken.
// in_stall is high while a transaction is in work or while a result waits
// in the output register; a stalled result holds until taken.
// Reset clears the state, keys, mode and phase to zero and empties the
// output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module ascon_aead128_engine_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ascon_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ascon_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data
);
	import ascon_pkg::*;

	// work left after the rounds finish
	localparam logic [3:0] TAIL_PLAIN    = 4'd0;
	localparam logic [3:0] TAIL_CLOSE_AD = 4'd1;
	localparam logic [3:0] TAIL_END_AD   = 4'd2;
	localparam logic [3:0] TAIL_TAG      = 4'd3;

	localparam out_item_t RES_ORDER_ERR = '{order_error: 1'b1, default: '0};

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PERM  = 6'b000010,
		ST_CLOSE = 6'b000100,
		ST_DATA  = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_DONE  = 6'b100000
	} fsm_t;

	fsm_t        st_q;
	logic [63:0] x_q [5];
	logic [63:0] x_rnd [5];
	logic [63:0] key_lo_q, key_hi_q;
	logic        dec_q;
	logic [1:0]  phase_q;
	logic        ad_seen_q;
	in_item_t    item_q;
	logic [4:0]  n_q;
	logic        emit_q;
	out_item_t   res_q;
	logic        rnd_start;
	logic [3:0]  rnd_cnt;
	logic        rnd_busy;
	logic [3:0]  tail_q;
	logic        accept;
	logic [4:0]  n_in;
	logic [63:0] m0, m1, d0, d1, p0, p1;
	logic        out_full_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE) || out_full_q;
	assign n_in     = (in_data.byte_count > 5'd16) ? 5'd16 : in_data.byte_count;

	ascon_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rnd_start),
		.rounds (rnd_cnt),
		.x_in   (x_q),
		.x_out  (x_rnd),
		.busy   (rnd_busy)
	);

	// masks and pad for the stored block
	always_comb begin
		m0 = byte_mask((n_q >= 5'd8) ? 4'd8 : n_q[3:0]);
		m1 = byte_mask((n_q > 5'd8) ? 4'(n_q - 5'd8) : 4'd0);
		d0 = item_q.data_word0 & m0;
		d1 = item_q.data_word1 & m1;
		p0 = (n_q < 5'd8) ? pad_word(n_q[2:0]) : 64'd0;
		p1 = (n_q >= 5'd8 && n_q < 5'd16) ? pad_word(n_q[2:0]) : 64'd0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			for (int i = 0; i < 5; i++) x_q[i] <= '0;
			key_lo_q   <= '0;
			key_hi_q   <= '0;
			dec_q      <= 1'b0;
			phase_q    <= PH_IDLE;
			ad_seen_q  <= 1'b0;
			out_full_q <= 1'b0;
			rnd_start  <= 1'b0;
			rnd_cnt    <= '0;
			tail_q     <= TAIL_PLAIN;
			emit_q     <= 1'b0;
			item_q     <= '0;
			n_q        <= '0;
			res_q      <= '0;
		end else begin
			rnd_start <= 1'b0;
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_lo_q <= cfg_data;
					CFG_KEY_HIGH: key_hi_q <= cfg_data;
					CFG_DECRYPT:  dec_q    <= cfg_data[0];
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= in_data;
						n_q    <= n_in;
						case (in_data.operation)
							OP_START: begin
								x_q[0] <= IV_AEAD128; x_q[1] <= key_lo_q;
								x_q[2] <= key_hi_q;
								x_q[3] <= in_data.data_word0;
								x_q[4] <= in_data.data_word1;
								rnd_start <= 1'b1; rnd_cnt <= ROUNDS_INIT;
								tail_q <= TAIL_PLAIN; emit_q <= 1'b0;
								phase_q <= PH_AD; ad_seen_q <= 1'b0;
								res_q <= '0;
								st_q <= ST_PERM;
							end
							OP_AD: begin
								if (phase_q != PH_AD) begin
									res_q <= RES_ORDER_ERR; out_full_q <= 1'b1;
								end else begin
									res_q <= '0;
									st_q <= ST_DATA;
								end
							end
							OP_MSG: begin
								if (phase_q == PH_IDLE || phase_q == PH_CLOSED) begin
									res_q <= RES_ORDER_ERR; out_full_q <= 1'b1;
								end else if (phase_q == PH_AD) begin
									res_q <= '0;
									st_q <= ST_CLOSE;
								end else begin
									res_q <= '0;
									st_q <= ST_DATA;
								end
							end
							default: begin
								if (phase_q == PH_IDLE) begin
									res_q <= RES_ORDER_ERR; out_full_q <= 1'b1;
								end else if (phase_q == PH_AD) begin
									res_q <= '0;
									st_q <= ST_CLOSE;
								end else begin
									res_q <= '0;
									st_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				// close AD: optional empty padded block, then domain bit
				ST_CLOSE: begin
					if (ad_seen_q) begin
						x_q[0] <= x_q[0] ^ 64'd1;
						rnd_start <= 1'b1; rnd_cnt <= ROUNDS_DATA;
						tail_q <= TAIL_CLOSE_AD;
						st_q <= ST_PERM;
					end else begin
						x_q[4] <= x_q[4] ^ DOMAIN_BIT;
						phase_q <= PH_MSG;
						st_q <= (item_q.operation == OP_MSG) ? ST_DATA : ST_FIN;
					end
					ad_seen_q <= 1'b0;
				end
				ST_DATA: begin
					if (item_q.operation == OP_AD) begin
						x_q[0] <= x_q[0] ^ d0 ^ p0;
						x_q[1] <= x_q[1] ^ d1 ^ p1;
						rnd_start <= 1'b1; rnd_cnt <= ROUNDS_DATA;
						emit_q <= 1'b0;
						if (n_q == 5'd16) begin
							ad_seen_q <= 1'b1; tail_q <= TAIL_PLAIN;
						end else begin
							ad_seen_q <= 1'b0; tail_q <= TAIL_END_AD;
						end
						st_q <= ST_PERM;
					end else begin
						res_q.out_bytes <= n_q;
						if (dec_q) begin
							res_q.out_word0 <= (x_q[0] ^ d0) & m0;
							res_q.out_word1 <= (x_q[1] ^ d1) & m1;
							x_q[0] <= ((x_q[0] & ~m0) | d0) ^ p0;
							x_q[1] <= ((x_q[1] & ~m1) | d1) ^ p1;
						end else begin
							res_q.out_word0 <= (x_q[0] ^ d0) & m0;
							res_q.out_word1 <= (x_q[1] ^ d1) & m1;
							x_q[0] <= x_q[0] ^ d0 ^ p0;
							x_q[1] <= x_q[1] ^ d1 ^ p1;
						end
						if (n_q == 5'd16) begin
							rnd_start <= 1'b1; rnd_cnt <= ROUNDS_DATA;
							tail_q <= TAIL_PLAIN; emit_q <= 1'b1;
							st_q <= ST_PERM;
						end else begin
							phase_q <= PH_CLOSED;
							out_full_q <= 1'b1;
							st_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					x_q[0] <= x_q[0] ^ ((phase_q == PH_MSG) ? 64'd1 : 64'd0);
					x_q[2] <= x_q[2] ^ key_lo_q;
					x_q[3] <= x_q[3] ^ key_hi_q;
					rnd_start <= 1'b1; rnd_cnt <= ROUNDS_INIT;
					tail_q <= TAIL_TAG; emit_q <= 1'b0;
					st_q <= ST_PERM;
				end
				ST_PERM: begin
					if (rnd_busy) begin
						for (int i = 0; i < 5; i++) x_q[i] <= x_rnd[i];
					end else if (!rnd_start) begin
						st_q <= ST_DONE;
					end
				end
				// finishing work after the rounds
				ST_DONE: begin
					case (tail_q)
						TAIL_PLAIN: begin
							if (item_q.operation == OP_START) begin
								x_q[3] <= x_q[3] ^ key_lo_q;
								x_q[4] <= x_q[4] ^ key_hi_q;
							end
							if (emit_q) out_full_q <= 1'b1;
							st_q <= ST_IDLE;
						end
						TAIL_CLOSE_AD: begin
							x_q[4] <= x_q[4] ^ DOMAIN_BIT;
							phase_q <= PH_MSG;
							st_q <= (item_q.operation == OP_MSG) ? ST_DATA : ST_FIN;
						end
						TAIL_END_AD: begin
							x_q[4] <= x_q[4] ^ DOMAIN_BIT;
							phase_q <= PH_MSG;
							st_q <= ST_IDLE;
						end
						default: begin
							res_q.out_word0 <= x_q[3] ^ key_lo_q;
							res_q.out_word1 <= x_q[4] ^ key_hi_q;
							res_q.out_bytes <= 5'd16;
							res_q.is_tag <= 1'b1;
							res_q.tag_match <= dec_q
								&& ((x_q[3] ^ key_lo_q) == item_q.data_word0)
								&& ((x_q[4] ^ key_hi_q) == item_q.data_word1);
							phase_q <= PH_IDLE;
							ad_seen_q <= 1'b0;
							out_full_q <= 1'b1;
							st_q <= ST_IDLE;
						end
					endcase
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_full_q;
	assign out_data  = res_q;

endmodule

// File: sv/ascon_aead128_engine_chk.sv
// ---------------------------------------------------------------------------
// ascon_aead128_engine_chk
// Port-level checker for the Ascon-AEAD128 engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ascon_aead128_engine_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input ascon_pkg::out_item_t out_data
);
	import ascon_pkg::*;

	// held result keeps its payload
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped or changed while stalled")
	// an error result carries no bytes and no tag flag
	`CHK_ALWAYS(a_err_clean, clk, arst_n, !(out_valid && out_data.order_error) || (out_data.out_bytes == 5'd0 && !out_data.is_tag), "order error result has payload")
	// tag results are always full width
	`CHK_ALWAYS(a_tag_len, clk, arst_n, !(out_valid && out_data.is_tag) || out_data.out_bytes == 5'd16, "tag result not 16 bytes")
	// no new transaction while a result waits
	`CHK_ALWAYS(a_no_accept_full, clk, arst_n, !(out_valid && in_valid && !in_stall), "input accepted while result pending")

endmodule

bind ascon_aead128_engine_top ascon_aead128_engine_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the Ascon-AEAD128 engine against an in-bench permutation and phase
// predictor: directed sequences, then random encrypt/decrypt sessions with
// random stalls on both channels and changes of key and mode between phases.
// ---------------------------------------------------------------------------
module testbench;
	import ascon_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_KEY_LOW;
	logic [63:0] cfg_data = '0;

	ascon_aead128_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the engine state and registers
	logic [63:0] ps [5];
	logic [1:0] phase;
	logic ad_open_full;
	logic [63:0] key_lo, key_hi;
	logic dec_mode;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int errors = 0;
	bit quiet = 1'b0;        // no random idling on either side
	bit hold_off = 1'b0;     // receiver holds off for a long stretch
	int hold_count = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [63:0] low_bytes(input int b);
		if (b >= 8) return '1;
		return (64'd1 << (8 * b)) - 64'd1;
	endfunction

	task automatic run_rounds(input int rounds);
		logic [63:0] t0, t1, t2, t3, t4;
		logic [3:0] idx;
		for (int i = 0; i < rounds; i++) begin
			idx = 4'(16 - rounds + i);
			ps[2] ^= {56'd0, 4'd3 - idx, idx + 4'd12};
			ps[0] ^= ps[4]; ps[4] ^= ps[3]; ps[2] ^= ps[1];
			t0 = ~ps[0] & ps[1]; t1 = ~ps[1] & ps[2]; t2 = ~ps[2] & ps[3];
			t3 = ~ps[3] & ps[4]; t4 = ~ps[4] & ps[0];
			ps[0] ^= t1; ps[1] ^= t2; ps[2] ^= t3; ps[3] ^= t4; ps[4] ^= t0;
			ps[1] ^= ps[0]; ps[0] ^= ps[4]; ps[3] ^= ps[2]; ps[2] = ~ps[2];
			ps[0] ^= rotr(ps[0], 19) ^ rotr(ps[0], 28);
			ps[1] ^= rotr(ps[1], 61) ^ rotr(ps[1], 39);
			ps[2] ^= rotr(ps[2], 1) ^ rotr(ps[2], 6);
			ps[3] ^= rotr(ps[3], 10) ^ rotr(ps[3], 17);
			ps[4] ^= rotr(ps[4], 7) ^ rotr(ps[4], 41);
		end
	endtask

	task automatic xor_pad(input int n);
		if (n < 8) ps[0] ^= 64'd1 << (8 * n);
		else ps[1] ^= 64'd1 << (8 * (n - 8));
	endtask

	task automatic end_ad();
		if (ad_open_full) begin
			xor_pad(0);
			run_rounds(8);
		end
		ad_open_full = 1'b0;
		ps[4] ^= DOMAIN_BIT;
		phase = PH_MSG;
	endtask

	// advance the predictor by one accepted transaction
	task automatic predict_engine(input in_item_t it);
		out_item_t r;
		int n;
		logic [63:0] m0, m1, d0, d1;
		r = '0;
		n = (it.byte_count > 16) ? 16 : int'(it.byte_count);
		m0 = low_bytes(n);
		m1 = low_bytes(n > 8 ? n - 8 : 0);
		d0 = it.data_word0 & m0;
		d1 = it.data_word1 & m1;
		case (it.operation)
			OP_START: begin
				ps[0] = IV_AEAD128; ps[1] = key_lo; ps[2] = key_hi;
				ps[3] = it.data_word0; ps[4] = it.data_word1;
				run_rounds(12);
				ps[3] ^= key_lo; ps[4] ^= key_hi;
				phase = PH_AD;
				ad_open_full = 1'b0;
				return;
			end
			OP_AD: begin
				if (phase != PH_AD) begin
					r.order_error = 1'b1;
				end else begin
					ps[0] ^= d0; ps[1] ^= d1;
					if (n == 16) begin
						run_rounds(8);
						ad_open_full = 1'b1;
					end else begin
						xor_pad(n);
						run_rounds(8);
						ad_open_full = 1'b0;
						ps[4] ^= DOMAIN_BIT;
						phase = PH_MSG;
					end
					return;
				end
			end
			OP_MSG: begin
				if (phase == PH_IDLE || phase == PH_CLOSED) begin
					r.order_error = 1'b1;
				end else begin
					if (phase == PH_AD) end_ad();
					if (dec_mode) begin
						r.out_word0 = (ps[0] ^ d0) & m0;
						r.out_word1 = (ps[1] ^ d1) & m1;
						ps[0] = (ps[0] & ~m0) | d0;
						ps[1] = (ps[1] & ~m1) | d1;
					end else begin
						ps[0] ^= d0; ps[1] ^= d1;
						r.out_word0 = ps[0] & m0;
						r.out_word1 = ps[1] & m1;
					end
					r.out_bytes = 5'(n);
					if (n == 16) run_rounds(8);
					else begin
						xor_pad(n);
						phase = PH_CLOSED;
					end
				end
			end
			default: begin
				if (phase == PH_IDLE) begin
					r.order_error = 1'b1;
				end else begin
					if (phase == PH_AD) end_ad();
					if (phase == PH_MSG) xor_pad(0);
					ps[2] ^= key_lo; ps[3] ^= key_hi;
					run_rounds(12);
					r.out_word0 = ps[3] ^ key_lo;
					r.out_word1 = ps[4] ^ key_hi;
					r.out_bytes = 5'd16;
					r.is_tag = 1'b1;
					r.tag_match = dec_mode && r.out_word0 == it.data_word0
						&& r.out_word1 == it.data_word1;
					phase = PH_IDLE;
					ad_open_full = 1'b0;
				end
			end
		endcase
		expected_results.push_back(r);
	endtask

	// driver: offer queued transactions, idling at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_engine(in_data);
				void'(pending_items.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (pending_items.size() > 0
					&& !(in_valid && !in_stall && pending_items.size() == 0)
					&& (quiet || $urandom_range(99) >= 25)) begin
				in_valid <= 1'b1;
				in_data <= pending_items[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check results against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation: %h", out_data);
					errors++;
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (out_data.out_word0 !== e.out_word0) begin
						$error("out_word0 exp %h got %h", e.out_word0, out_data.out_word0);
						errors++;
					end
					if (out_data.out_word1 !== e.out_word1) begin
						$error("out_word1 exp %h got %h", e.out_word1, out_data.out_word1);
						errors++;
					end
					if (out_data.out_bytes !== e.out_bytes) begin
						$error("out_bytes exp %0d got %0d", e.out_bytes, out_data.out_bytes);
						errors++;
					end
					if (out_data.is_tag !== e.is_tag) begin
						$error("is_tag exp %b got %b", e.is_tag, out_data.is_tag);
						errors++;
					end
					if (out_data.tag_match !== e.tag_match) begin
						$error("tag_match exp %b got %b", e.tag_match, out_data.tag_match);
						errors++;
					end
					if (out_data.order_error !== e.order_error) begin
						$error("order_error exp %b got %b", e.order_error,
							out_data.order_error);
						errors++;
					end
				end
			end
			// receiver stall; a long hold-off is counted here
			if (hold_off && hold_count < 300) begin
				hold_count++;
				out_stall <= 1'b1;
			end else begin
				if (hold_off) hold_off = 1'b0;
				out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);
			end
		end
	end

	// watchdog: cycles with no accepted transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [1:0] op, input logic [63:0] w0,
			input logic [63:0] w1, input logic [4:0] cnt);
		in_item_t it;
		it.operation = op; it.data_word0 = w0; it.data_word1 = w1; it.byte_count = cnt;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// wait until all queued work is accepted and all results have arrived
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KEY_LOW) key_lo = val;
		else if (idx == CFG_KEY_HIGH) key_hi = val;
		else dec_mode = val[0];
	endtask

	// one session with random content; mostly well formed
	task automatic queue_session();
		int n_ad, n_msg;
		logic [4:0] cnt;
		pending_items.push_back(make_item(OP_START, rand64(), rand64(), 5'($urandom)));
		n_ad = $urandom_range(3);
		for (int i = 0; i < n_ad; i++) begin
			cnt = (i == n_ad - 1 && $urandom_range(1)) ? 5'($urandom_range(15))
				: 5'($urandom_range(16, 31));
			pending_items.push_back(make_item(OP_AD, rand64(), rand64(), cnt));
		end
		n_msg = $urandom_range(3);
		for (int i = 0; i < n_msg; i++) begin
			cnt = (i == n_msg - 1 && $urandom_range(1)) ? 5'($urandom_range(15))
				: (($urandom_range(9) == 0) ? 5'($urandom) : 5'd16);
			pending_items.push_back(make_item(OP_MSG, rand64(), rand64(), cnt));
		end
		if ($urandom_range(9) == 0)
			pending_items.push_back(make_item(2'($urandom), rand64(), rand64(),
				5'($urandom)));
		pending_items.push_back(make_item(OP_FINISH, rand64(), rand64(), 5'($urandom)));
	endtask

	initial begin
		int queued;
		for (int i = 0; i < 5; i++) ps[i] = '0;
		phase = PH_IDLE; ad_open_full = 1'b0;
		key_lo = '0; key_hi = '0; dec_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: order errors from idle, zero key, extremes of fields
		quiet = 1'b1;
		pending_items.push_back(make_item(OP_MSG, '1, '1, 5'd16));
		pending_items.push_back(make_item(OP_FINISH, '0, '0, 5'd0));
		pending_items.push_back(make_item(OP_AD, '1, '1, 5'd31));
		pending_items.push_back(make_item(OP_START, '0, '0, 5'd0));
		pending_items.push_back(make_item(OP_FINISH, '0, '0, 5'd0));
		pending_items.push_back(make_item(OP_START, '1, '1, 5'd31));
		pending_items.push_back(make_item(OP_AD, '1, '1, 5'd16));
		pending_items.push_back(make_item(OP_MSG, '1, '1, 5'd0));
		pending_items.push_back(make_item(OP_MSG, '1, '1, 5'd9));
		pending_items.push_back(make_item(OP_AD, '1, '1, 5'd3));
		pending_items.push_back(make_item(OP_FINISH, '1, '1, 5'd31));
		drain();
		write_reg(CFG_KEY_LOW, '1);
		write_reg(CFG_KEY_HIGH, '1);
		write_reg(CFG_DECRYPT, 64'd1);
		pending_items.push_back(make_item(OP_START, 64'h0123456789abcdef, '0, 5'd0));
		pending_items.push_back(make_item(OP_AD, rand64(), rand64(), 5'd16));
		pending_items.push_back(make_item(OP_FINISH, '0, '0, 5'd0));
		pending_items.push_back(make_item(OP_START, '0, '1, 5'd0));
		pending_items.push_back(make_item(OP_AD, rand64(), rand64(), 5'd7));
		pending_items.push_back(make_item(OP_MSG, rand64(), rand64(), 5'd16));
		pending_items.push_back(make_item(OP_START, '0, '1, 5'd0));
		pending_items.push_back(make_item(OP_MSG, rand64(), rand64(), 5'd8));
		pending_items.push_back(make_item(OP_MSG, rand64(), rand64(), 5'd1));
		drain();
		// matching tag in decrypt mode: replay with the computed tag
		begin
			logic [63:0] sv_ps [5];
			logic [1:0] sv_ph;
			logic sv_ad;
			out_item_t tag;
			sv_ps = ps; sv_ph = phase; sv_ad = ad_open_full;
			predict_engine(make_item(OP_START, 64'h55, 64'haa, 5'd0));
			predict_engine(make_item(OP_MSG, 64'h1234, '0, 5'd2));
			predict_engine(make_item(OP_FINISH, '0, '0, 5'd0));
			tag = expected_results.pop_back();
			void'(expected_results.pop_back());
			ps = sv_ps; phase = sv_ph; ad_open_full = sv_ad;
			pending_items.push_back(make_item(OP_START, 64'h55, 64'haa, 5'd0));
			pending_items.push_back(make_item(OP_MSG, 64'h1234, '0, 5'd2));
			pending_items.push_back(make_item(OP_FINISH, tag.out_word0, tag.out_word1,
				5'd0));
		end
		drain();

		// random sessions in phases with new key and mode
		quiet = 1'b0;
		queued = 0;
		for (int p = 0; queued < 850; p++) begin
			write_reg(CFG_KEY_LOW, (p % 4 == 3) ? 64'd0 : rand64());
			write_reg(CFG_KEY_HIGH, (p % 4 == 3) ? 64'd0 : rand64());
			write_reg(CFG_DECRYPT, 64'(p % 2));
			quiet = (p == 2);
			if (p == 1) begin
				hold_count = 0;
				hold_off = 1'b1;
			end
			for (int s = 0; s < 20; s++) begin
				queue_session();
			end
			queued += pending_items.size();
			drain();
		end
		quiet = 1'b0;
		drain();

		if (errors == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/ascon_pkg.sv
sv/ascon_round.sv
sv/ascon_aead128_engine_top.sv
sv/ascon_aead128_engine_chk.sv
tb/testbench.sv
